[hw/rtl/smia_pkg.sv]
`default_nettype none
package smia_pkg;

   localparam int MaxSize      = 4;
   localparam int ElemWidth    = 8;
   localparam int AdjWidth     = 26;
   localparam int DetWidth     = 36;
   localparam int ProdWidth    = 22;
   localparam int FracBits     = 16;
   localparam int InvWidth     = 48;
   localparam int QuoWidth     = AdjWidth + FracBits;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_TERM,
      ST_COF_WRITE,
      ST_COF_DET,
      ST_CHECK,
      ST_DIV_READ,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

   // Column slots of the six permutations of a 3x3 determinant, slot 0 in the low bits.
   localparam logic [5:0] PERM_TABLE [6] = '{
      6'b10_01_00, 6'b01_10_00, 6'b10_00_01,
      6'b00_10_01, 6'b01_00_10, 6'b00_01_10
   };
   localparam logic [5:0] PERM_NEG = 6'b100110;

   // Index of the k-th row or column of a minor that leaves out x.
   function automatic logic [1:0] skip_index(input logic [1:0] k, input logic [1:0] x);
      logic [1:0] r;
      r = (k < x) ? k : k + 2'd1;
      return r;
   endfunction

   function automatic logic [1:0] perm_slot(input logic [2:0] term, input logic [1:0] pos);
      logic [5:0] p;
      p = PERM_TABLE[term];
      return p[2*pos +: 2];
   endfunction

endpackage
`default_nettype wire

[hw/rtl/smia_divider.sv]
`default_nettype none
// Signed restoring divider: quotient = (dividend * 2^16) / divisor, truncated toward zero.
// One quotient bit per cycle.
module smia_divider (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [smia_pkg::AdjWidth-1:0] dividend,
   input  wire logic signed [smia_pkg::DetWidth-1:0] divisor,
   output logic                                     done,
   output logic signed [smia_pkg::InvWidth-1:0]     quotient
);

   localparam int QW = smia_pkg::QuoWidth;
   localparam int DW = smia_pkg::DetWidth;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff, div_in;

   logic [smia_pkg::AdjWidth-1:0] num_mag;
   logic [DW-1:0]                 den_mag;
   logic [DW:0]                   trial;
   logic [DW:0]                   diff;

   always_comb begin
      num_mag = dividend[smia_pkg::AdjWidth-1] ? -dividend : dividend;
      den_mag = divisor[DW-1] ? -divisor : divisor;
      trial   = {rem_ff, quo_ff[QW-1]};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         neg_in  = dividend[smia_pkg::AdjWidth-1] ^ divisor[DW-1];
         quo_in  = {num_mag, {smia_pkg::FracBits{1'b0}}};
         rem_in  = '0;
         div_in  = den_mag;
      end else if (busy_ff) begin
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -{{(smia_pkg::InvWidth-QW){1'b0}}, quo_ff}
                            :  {{(smia_pkg::InvWidth-QW){1'b0}}, quo_ff};

endmodule
`default_nettype wire

[hw/rtl/small_matrix_inverse_adjugate.sv]
`default_nettype none
// Inverse of a small signed integer matrix by adjugate and determinant.
// Elements enter on the req_ channel, one 8-bit word each, row-major. The size in use
// (1 to 4) comes from csr_wr_data when csr_wr_en is high; a write also drops a partial load.
// After the last element the block computes all sixteen 3x3 cofactors of the matrix padded
// to 4x4 with an identity block, using one shared multiplier, and the determinant from the
// first row. Each inverse entry then takes its own divider pass, one entry after another.
// Results leave row-major on the rsp_ channel with the final word marked by rsp_tlast;
// a singular matrix gives one word with rsp_tuser set and a zero value.
// req_tready is high only while loading. A stalled receiver holds the block at the current
// result word until it is taken. Reset makes the size 4 and empties the load.
module small_matrix_inverse_adjugate (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // element_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // inv_value[47:0], row_index[49:48], col_index[51:50]
   output logic             rsp_tuser,   // singular
   output logic             rsp_tlast,   // last
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_wr_data  // matrix_size
);

   localparam int AW = smia_pkg::AdjWidth;
   localparam int DW = smia_pkg::DetWidth;
   localparam int PW = smia_pkg::ProdWidth;
   localparam int EW = smia_pkg::ElemWidth;

   smia_pkg::state_type state_ff, state_in;

   logic [2:0] size_ff, size_in;
   logic [1:0] nm1;
   logic [1:0] ld_row_ff, ld_row_in, ld_col_ff, ld_col_in;
   logic [1:0] ci_ff, ci_in, cj_ff, cj_in;
   logic [2:0] term_ff, term_in;
   logic [2:0] sub_ff, sub_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [AW-1:0] cof_ff, cof_in;
   logic signed [DW-1:0] det_ff, det_in;
   logic [1:0] oi_ff, oi_in, oj_ff, oj_in;
   logic [smia_pkg::InvWidth-1:0] out_val_ff, out_val_in;
   logic out_sing_ff, out_sing_in, out_last_ff, out_last_in;

   logic [EW-1:0] mat_mem [16];
   logic signed [AW-1:0] adj_mem [16];
   logic [EW-1:0] mat_rd_ff;
   logic pad_ff, one_ff;
   logic signed [AW-1:0] adj_rd_ff;

   logic [1:0] rd_row, rd_col;
   logic signed [EW-1:0] elem;
   logic signed [AW-1:0] mul_a;
   logic signed [EW-1:0] mul_b;
   logic signed [AW+EW-1:0] mul_p;
   logic signed [AW-1:0] cof_val;
   logic adj_we;
   logic div_start, div_done;
   logic signed [smia_pkg::InvWidth-1:0] div_q;

   always_comb begin
      if (size_ff == 3'd0) begin
         nm1 = 2'd0;
      end else if (size_ff > 3'(smia_pkg::MaxSize)) begin
         nm1 = 2'(smia_pkg::MaxSize - 1);
      end else begin
         nm1 = 2'(size_ff - 3'd1);
      end
   end

   assign elem  = pad_ff ? {{(EW-1){1'b0}}, one_ff} : mat_rd_ff;
   assign mul_p = mul_a * mul_b;
   assign cof_val = (ci_ff[0] ^ cj_ff[0]) ? -acc_ff : acc_ff;

   always_comb begin
      if (state_ff == smia_pkg::ST_TERM) begin
         rd_row = smia_pkg::skip_index(sub_ff[1:0], ci_ff);
         rd_col = smia_pkg::skip_index(smia_pkg::perm_slot(term_ff, sub_ff[1:0]), cj_ff);
      end else begin
         rd_row = 2'd0;
         rd_col = cj_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         mat_mem[{ld_row_ff, ld_col_ff}] <= req_tdata;
      end
      mat_rd_ff <= mat_mem[{rd_row, rd_col}];
      pad_ff    <= (rd_row > nm1) || (rd_col > nm1);
      one_ff    <= (rd_row == rd_col);
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[{cj_ff, ci_ff}] <= cof_val;
      end
      adj_rd_ff <= adj_mem[{oi_ff, oj_ff}];
   end

   smia_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (adj_rd_ff),
      .divisor  (det_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in    = state_ff;
      size_in     = size_ff;
      ld_row_in   = ld_row_ff;
      ld_col_in   = ld_col_ff;
      ci_in       = ci_ff;
      cj_in       = cj_ff;
      term_in     = term_ff;
      sub_in      = sub_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      cof_in      = cof_ff;
      det_in      = det_ff;
      oi_in       = oi_ff;
      oj_in       = oj_ff;
      out_val_in  = out_val_ff;
      out_sing_in = out_sing_ff;
      out_last_in = out_last_ff;
      mul_a       = AW'(prod_ff);
      mul_b       = elem;
      adj_we      = 1'b0;
      div_start   = 1'b0;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;

      case (state_ff)
         smia_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (ld_col_ff == nm1) begin
                  ld_col_in = 2'd0;
                  if (ld_row_ff == nm1) begin
                     ld_row_in = 2'd0;
                     ci_in     = 2'd0;
                     cj_in     = 2'd0;
                     term_in   = 3'd0;
                     sub_in    = 3'd0;
                     acc_in    = '0;
                     det_in    = '0;
                     state_in  = smia_pkg::ST_TERM;
                  end else begin
                     ld_row_in = ld_row_ff + 2'd1;
                  end
               end else begin
                  ld_col_in = ld_col_ff + 2'd1;
               end
            end
         end
         smia_pkg::ST_TERM: begin
            sub_in = sub_ff + 3'd1;
            case (sub_ff)
               3'd1: prod_in = PW'(elem);
               3'd2, 3'd3: prod_in = PW'(mul_p);
               3'd4: begin
                  if (smia_pkg::PERM_NEG[term_ff]) begin
                     acc_in = acc_ff - AW'(prod_ff);
                  end else begin
                     acc_in = acc_ff + AW'(prod_ff);
                  end
                  sub_in = 3'd0;
                  if (term_ff == 3'd5) begin
                     term_in  = 3'd0;
                     state_in = smia_pkg::ST_COF_WRITE;
                  end else begin
                     term_in = term_ff + 3'd1;
                  end
               end
               default: ;
            endcase
         end
         smia_pkg::ST_COF_WRITE: begin
            // Cofactor (i, j) is stored at adjugate position (j, i).
            adj_we = 1'b1;
            cof_in = cof_val;
            acc_in = '0;
            state_in = smia_pkg::ST_COF_DET;
         end
         smia_pkg::ST_COF_DET: begin
            mul_a = cof_ff;
            if (ci_ff == 2'd0) begin
               det_in = det_ff + DW'(mul_p);
            end
            state_in = smia_pkg::ST_TERM;
            if (cj_ff == 2'd3) begin
               cj_in = 2'd0;
               if (ci_ff == 2'd3) begin
                  state_in = smia_pkg::ST_CHECK;
               end else begin
                  ci_in = ci_ff + 2'd1;
               end
            end else begin
               cj_in = cj_ff + 2'd1;
            end
         end
         smia_pkg::ST_CHECK: begin
            oi_in = 2'd0;
            oj_in = 2'd0;
            if (det_ff == '0) begin
               out_val_in  = '0;
               out_sing_in = 1'b1;
               out_last_in = 1'b1;
               state_in    = smia_pkg::ST_EMIT;
            end else begin
               out_sing_in = 1'b0;
               state_in    = smia_pkg::ST_DIV_READ;
            end
         end
         smia_pkg::ST_DIV_READ: begin
            state_in = smia_pkg::ST_DIV_START;
         end
         smia_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = smia_pkg::ST_DIV_WAIT;
         end
         smia_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               out_val_in  = div_q;
               out_last_in = (oi_ff == nm1) && (oj_ff == nm1);
               state_in    = smia_pkg::ST_EMIT;
            end
         end
         smia_pkg::ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (out_last_ff) begin
                  state_in = smia_pkg::ST_LOAD;
               end else begin
                  state_in = smia_pkg::ST_DIV_READ;
                  if (oj_ff == nm1) begin
                     oj_in = 2'd0;
                     oi_in = oi_ff + 2'd1;
                  end else begin
                     oj_in = oj_ff + 2'd1;
                  end
               end
            end
         end
         default: state_in = smia_pkg::ST_LOAD;
      endcase

      if (csr_wr_en) begin
         size_in   = csr_wr_data;
         ld_row_in = 2'd0;
         ld_col_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= smia_pkg::ST_LOAD;
         size_ff   <= 3'(smia_pkg::MaxSize);
         ld_row_ff <= 2'd0;
         ld_col_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         size_ff   <= size_in;
         ld_row_ff <= ld_row_in;
         ld_col_ff <= ld_col_in;
      end
      ci_ff       <= ci_in;
      cj_ff       <= cj_in;
      term_ff     <= term_in;
      sub_ff      <= sub_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      cof_ff      <= cof_in;
      det_ff      <= det_in;
      oi_ff       <= oi_in;
      oj_ff       <= oj_in;
      out_val_ff  <= out_val_in;
      out_sing_ff <= out_sing_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tdata = {4'd0, oj_ff, oi_ff, out_val_ff};
   assign rsp_tuser = out_sing_ff;
   assign rsp_tlast = out_last_ff;

endmodule
`default_nettype wire
